// ----- hw/rtl/wcts_pkg.sv -----
// Package for the weak-coupling temperature scaler.
// Field widths, stream packing offsets, fixed-point constants and register indexes.
// No dependencies.
package wcts_pkg;

    localparam int GROUPS_DEFAULT = 16;

    localparam int GROUP_W = 4;
    localparam int TEMP_W  = 24;
    localparam int TAU_W   = 20;
    localparam int FAC_W   = 16;
    localparam int CFG_W   = 10;
    localparam int SCALE_W = 15;

    localparam int CFG_ADDR_W = 4;

    localparam int OFF_GROUP = 0;
    localparam int OFF_MEAS  = OFF_GROUP + GROUP_W;
    localparam int OFF_REF   = OFF_MEAS + TEMP_W;
    localparam int OFF_TAU   = OFF_REF + TEMP_W;
    localparam int OFF_FAC   = OFF_TAU + TAU_W;
    localparam int IN_BITS   = OFF_FAC + FAC_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OFF_SCALE  = GROUP_W;
    localparam int OFF_AVG    = OFF_SCALE + SCALE_W;
    localparam int OUT_BITS   = OFF_AVG + TEMP_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int ACC_W  = CFG_W + TEMP_W;
    localparam int PROD_W = TEMP_W + FAC_W - 1;
    localparam int DEN_W  = TAU_W + TEMP_W;
    localparam int DIFF_W = TEMP_W + 1;
    localparam int DTP_W  = CFG_W + 1 + DIFF_W;
    localparam int NUM_W  = DEN_W + 2;
    localparam int REM_W  = DEN_W + 1;
    localparam int CMP_W  = NUM_W + 5;
    localparam int Q_W    = 29;
    localparam int SQ_W   = 30;
    localparam int CNT_W  = 5;

    localparam int FRAC_SHIFT = 14;

    localparam logic [CNT_W-1:0] AVG_STEPS  = CNT_W'(TEMP_W);
    localparam logic [CNT_W-1:0] FRAC_STEPS = CNT_W'(Q_W - 1);
    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(SQ_W / 2);

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [SQ_W-1:0]   SQ_BIT0    = SQ_W'(1) << (SQ_W - 2);

    localparam logic [SCALE_W-1:0] SCALE_ONE = 15'd16384;
    localparam logic [SCALE_W-1:0] SCALE_MIN = 15'd13107;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 15'd20480;
    localparam logic [TEMP_W-1:0]  TEMP_MAX  = 24'hFFFFFF;

    localparam logic [CFG_W-1:0] DT_RESET      = 10'd2;
    localparam logic [CFG_W-1:0] AVG_MEM_RESET = 10'd1;

    localparam logic [CFG_ADDR_W-1:0] REG_TIMESTEP   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AVG_MEMORY = 4'd1;

endpackage

// ----- hw/rtl/weak_coupling_temperature_scaler_unit.sv -----
// Top level of the weak-coupling temperature scaler: per-group running average and
// velocity scale through bit-serial dividers and a bit-serial square root.
// Depends on wcts_pkg and wcts_ram.
//
// One item at a time. After the input transfer an item with coupling active runs the
// running-average divider (one quotient bit a cycle), the radicand quotient divider
// and the square root (one root bit a cycle); a new item is taken once the result has
// moved to the output register. Items with coupling off, zero average or zero
// coupling time skip the radicand path; a radicand at or beyond a clamp bound skips
// the quotient divider and square root; a group at or beyond GROUPS skips the average
// too. A finished result waits in the output register while the next item is already
// taken. Seed flags clear at reset at once; the average RAM needs no clearing.
module weak_coupling_temperature_scaler_unit #(
    parameter int GROUPS = wcts_pkg::GROUPS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: group[3:0], measured_temp[27:4], ref_temp[51:28],
    //        coupling_time_fs[71:52], anneal_factor[87:72]
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [wcts_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // tuser: coupling_on[0]
    input  logic                                i_s_axis_tuser,
    // tdata: group_out[3:0], scale[18:4], average_temp[42:19], zero fill above
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [wcts_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wcts_pkg::CFG_ADDR_W-1:0]     i_cfg_index,
    input  logic [wcts_pkg::CFG_W-1:0]          i_cfg_data
);
    import wcts_pkg::*;

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int IW = (GW > GROUP_W) ? GW : GROUP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT,
        S_ACC,
        S_DIVA,
        S_AVG,
        S_NUM,
        S_CMP,
        S_DIVQ,
        S_SQRT,
        S_CLAMP,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_dt, n_dt;
    logic [CFG_W-1:0]   r_avg_mem, n_avg_mem;
    logic [GROUPS-1:0]  r_seeded, n_seeded;
    logic               r_o_valid, n_o_valid;
    logic [GROUP_W-1:0] r_o_grp, n_o_grp;
    logic [SCALE_W-1:0] r_o_scale, n_o_scale;
    logic [TEMP_W-1:0]  r_o_avg, n_o_avg;

    logic [GROUP_W-1:0] r_grp, n_grp;
    logic [TEMP_W-1:0]  r_cur, n_cur;
    logic [TEMP_W-1:0]  r_ref, n_ref;
    logic [TAU_W-1:0]   r_tau, n_tau;
    logic [FAC_W-1:0]   r_fac, n_fac;
    logic               r_on, n_on;
    logic [TEMP_W-1:0]  r_target, n_target;
    logic [CFG_W-1:0]   r_arem, n_arem;
    logic [TEMP_W-1:0]  r_aquo, n_aquo;
    logic [TEMP_W-1:0]  r_avg, n_avg;
    logic [DEN_W-1:0]   r_den, n_den;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0]   r_qrem, n_qrem;
    logic [Q_W-1:0]     r_q, n_q;
    logic [SQ_W-1:0]    r_sv, n_sv;
    logic [SQ_W-1:0]    r_res, n_res;
    logic [SQ_W-1:0]    r_bit, n_bit;
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic [IW-1:0]      grp_ext;
    logic [GW-1:0]      idx;
    logic               in_range;
    logic [TEMP_W-1:0]  ram_rdata;
    logic               ram_we;
    logic [CFG_W-1:0]   n_eff;
    logic               s_accept;

    logic               fac_pos;
    logic [PROD_W-1:0]  tgt_rnd;
    logic [TEMP_W:0]    tgt_q;
    logic [TEMP_W-1:0]  tgt_val;
    logic [TEMP_W-1:0]  old_avg;
    logic [ACC_W-1:0]   acc;
    logic [CFG_W:0]     a_try;
    logic               a_ge;
    logic [CFG_W:0]     a_sub;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DTP_W-1:0]  dtp;
    logic [NUM_W-2:0]   nm;
    logic               nonpos;
    logic [CMP_W-1:0]   n16, n25, d16, d25;
    logic               q0_ge;
    logic [NUM_W-2:0]   q0_sub;
    logic [REM_W-1:0]   q_try;
    logic               q_ge;
    logic [REM_W-1:0]   q_sub;
    logic [Q_W-1:0]     q_next;
    logic [SQ_W-1:0]    s_rb;
    logic               s_ge;
    logic [SCALE_W-1:0] s_root;

    assign grp_ext  = IW'(r_grp);
    assign idx      = grp_ext[GW-1:0];
    assign in_range = 32'(r_grp) < 32'(GROUPS);
    assign n_eff    = (r_avg_mem == '0) ? CFG_W'(1) : r_avg_mem;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign ram_we   = (r_state == S_AVG);

    wcts_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (GROUPS)
    ) u_avg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx),
        .i_wdata (r_aquo),
        .i_raddr (idx),
        .o_rdata (ram_rdata)
    );

    // target: rounded product of reference and positive annealing factor, saturated
    assign fac_pos = !r_fac[FAC_W-1] && (r_fac != '0);
    assign tgt_rnd = r_ref * r_fac[FAC_W-2:0] + ROUND_HALF;
    assign tgt_q   = tgt_rnd[PROD_W-1:FRAC_SHIFT];
    assign tgt_val = !fac_pos ? '0 : (tgt_q[TEMP_W] ? TEMP_MAX : tgt_q[TEMP_W-1:0]);

    assign old_avg = r_seeded[idx] ? ram_rdata : r_target;
    assign acc     = ACC_W'(n_eff - CFG_W'(1)) * ACC_W'(old_avg) + ACC_W'(r_cur)
                   + ACC_W'(n_eff[CFG_W-1:1]);

    assign a_try = {r_arem, r_aquo[TEMP_W-1]};
    assign a_ge  = a_try >= {1'b0, n_eff};
    assign a_sub = a_try - {1'b0, n_eff};

    assign diff = $signed({1'b0, r_target}) - $signed({1'b0, r_avg});
    assign dtp  = $signed({1'b0, r_dt}) * diff;

    assign nm     = r_num[NUM_W-2:0];
    assign nonpos = r_num[NUM_W-1] || (r_num == '0);
    assign n16    = CMP_W'(nm) << 4;
    assign n25    = (CMP_W'(nm) << 4) + (CMP_W'(nm) << 3) + CMP_W'(nm);
    assign d16    = CMP_W'(r_den) << 4;
    assign d25    = (CMP_W'(r_den) << 4) + (CMP_W'(r_den) << 3) + CMP_W'(r_den);
    assign q0_ge  = nm >= (NUM_W-1)'(r_den);
    assign q0_sub = nm - (NUM_W-1)'(r_den);

    assign q_try  = {r_qrem, 1'b0};
    assign q_ge   = q_try >= {1'b0, r_den};
    assign q_sub  = q_try - {1'b0, r_den};
    assign q_next = {r_q[Q_W-2:0], q_ge};

    assign s_rb   = r_res + r_bit;
    assign s_ge   = r_sv >= s_rb;
    assign s_root = r_res[SCALE_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_dt      = r_dt;
        n_avg_mem = r_avg_mem;
        n_seeded  = r_seeded;
        n_o_valid = r_o_valid;
        n_o_grp   = r_o_grp;
        n_o_scale = r_o_scale;
        n_o_avg   = r_o_avg;
        n_grp     = r_grp;
        n_cur     = r_cur;
        n_ref     = r_ref;
        n_tau     = r_tau;
        n_fac     = r_fac;
        n_on      = r_on;
        n_target  = r_target;
        n_arem    = r_arem;
        n_aquo    = r_aquo;
        n_avg     = r_avg;
        n_den     = r_den;
        n_num     = r_num;
        n_qrem    = r_qrem;
        n_q       = r_q;
        n_sv      = r_sv;
        n_res     = r_res;
        n_bit     = r_bit;
        n_scale   = r_scale;
        n_cnt     = r_cnt;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIMESTEP:   n_dt      = i_cfg_data;
                REG_AVG_MEMORY: n_avg_mem = i_cfg_data;
                default: ;
            endcase
        end

        if (r_o_valid && i_m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_grp   = i_s_axis_tdata[OFF_GROUP +: GROUP_W];
                    n_cur   = i_s_axis_tdata[OFF_MEAS +: TEMP_W];
                    n_ref   = i_s_axis_tdata[OFF_REF +: TEMP_W];
                    n_tau   = i_s_axis_tdata[OFF_TAU +: TAU_W];
                    n_fac   = i_s_axis_tdata[OFF_FAC +: FAC_W];
                    n_on    = i_s_axis_tuser;
                    n_state = S_TGT;
                end
            end
            S_TGT: begin
                n_target = tgt_val;
                if (in_range) begin
                    n_state = S_ACC;
                end else begin
                    n_scale = SCALE_ONE;
                    n_avg   = '0;
                    n_state = S_DONE;
                end
            end
            S_ACC: begin
                n_seeded[idx] = 1'b1;
                n_arem  = acc[ACC_W-1:TEMP_W];
                n_aquo  = acc[TEMP_W-1:0];
                n_cnt   = AVG_STEPS;
                n_state = S_DIVA;
            end
            S_DIVA: begin
                n_arem = a_ge ? a_sub[CFG_W-1:0] : a_try[CFG_W-1:0];
                n_aquo = {r_aquo[TEMP_W-2:0], a_ge};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                n_avg = r_aquo;
                n_den = DEN_W'(r_tau) * DEN_W'(r_aquo);
                if (!r_on || r_aquo == '0 || r_tau == '0) begin
                    n_scale = SCALE_ONE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                n_num   = $signed({2'b00, r_den}) + $signed({{(NUM_W-DTP_W){dtp[DTP_W-1]}}, dtp});
                n_state = S_CMP;
            end
            S_CMP: begin
                if (nonpos || n25 <= d16) begin
                    n_scale = SCALE_MIN;
                    n_state = S_DONE;
                end else if (n16 >= d25) begin
                    n_scale = SCALE_MAX;
                    n_state = S_DONE;
                end else begin
                    n_qrem  = q0_ge ? q0_sub[DEN_W-1:0] : nm[DEN_W-1:0];
                    n_q     = Q_W'(q0_ge);
                    n_cnt   = FRAC_STEPS;
                    n_state = S_DIVQ;
                end
            end
            S_DIVQ: begin
                n_qrem = q_ge ? q_sub[DEN_W-1:0] : q_try[DEN_W-1:0];
                n_q    = q_next;
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_sv    = SQ_W'(q_next);
                    n_res   = '0;
                    n_bit   = SQ_BIT0;
                    n_cnt   = SQRT_STEPS;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_sv  = s_ge ? r_sv - s_rb : r_sv;
                n_res = s_ge ? (r_res >> 1) + r_bit : r_res >> 1;
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (s_root < SCALE_MIN) begin
                    n_scale = SCALE_MIN;
                end else if (s_root > SCALE_MAX) begin
                    n_scale = SCALE_MAX;
                end else begin
                    n_scale = s_root;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid = 1'b1;
                    n_o_grp   = r_grp;
                    n_o_scale = r_scale;
                    n_o_avg   = r_avg;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dt      <= DT_RESET;
            r_avg_mem <= AVG_MEM_RESET;
            r_seeded  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dt      <= n_dt;
            r_avg_mem <= n_avg_mem;
            r_seeded  <= n_seeded;
            r_o_valid <= n_o_valid;
        end
        r_o_grp   <= n_o_grp;
        r_o_scale <= n_o_scale;
        r_o_avg   <= n_o_avg;
    end

    always_ff @(posedge i_clk) begin
        r_grp    <= n_grp;
        r_cur    <= n_cur;
        r_ref    <= n_ref;
        r_tau    <= n_tau;
        r_fac    <= n_fac;
        r_on     <= n_on;
        r_target <= n_target;
        r_arem   <= n_arem;
        r_aquo   <= n_aquo;
        r_avg    <= n_avg;
        r_den    <= n_den;
        r_num    <= n_num;
        r_qrem   <= n_qrem;
        r_q      <= n_q;
        r_sv     <= n_sv;
        r_res    <= n_res;
        r_bit    <= n_bit;
        r_scale  <= n_scale;
        r_cnt    <= n_cnt;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, r_o_avg, r_o_scale, r_o_grp};
    assign o_cfg_ready     = 1'b1;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("input taken while an item is in progress");

    a_scale_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_o_scale >= SCALE_MIN && r_o_scale <= SCALE_MAX))
        else $error("scale outside clamp range");

    a_avg_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVA) |-> (r_arem < n_eff))
        else $error("average divider remainder not below divisor");

    a_quo_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVQ) |-> (r_qrem < r_den))
        else $error("radicand divider remainder not below divisor");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot(r_bit))
        else $error("square root bit lost");

endmodule

// ----- hw/rtl/wcts_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wcts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- test/weak_coupling_temperature_scaler_unit_test.sv -----
// Testbench for weak_coupling_temperature_scaler_unit: streams coupling-group items, predicts
// each group's running average and velocity scale, and checks every result transfer.
// Depends on wcts_pkg and the scaler RTL; needs no other file.
module weak_coupling_temperature_scaler_unit_test;
    import wcts_pkg::*;

    localparam int GROUP_COUNT  = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_PERCENT = 15;
    localparam int HOLD_CYCLES  = 600;
    localparam int SWEEP_ITEMS  = 150;
    localparam int ANNEAL_ONE   = 16384;
    localparam int TEMP_300K    = 76800;
    localparam int TAU_MAX      = 1048575;

    localparam logic [CFG_W-1:0] SWEEP_DT  [6] = '{10'd0, 10'd1, 10'd1023, 10'd1000, 10'd37,
                                                   10'd250};
    localparam logic [CFG_W-1:0] SWEEP_MEM [6] = '{10'd0, 10'd1023, 10'd1, 10'd2, 10'd16,
                                                   10'd500};

    typedef struct {
        logic [GROUP_W-1:0]      group;
        logic [TEMP_W-1:0]       measured;
        logic [TEMP_W-1:0]       ref_temp;
        logic [TAU_W-1:0]        tau;
        logic signed [FAC_W-1:0] anneal;
        logic                    coupling_on;
    } t_coupling_item;

    typedef struct {
        logic [GROUP_W-1:0] group;
        logic [SCALE_W-1:0] scale;
        logic [TEMP_W-1:0]  average;
    } t_scale_result;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index     = REG_TIMESTEP;
    logic [CFG_W-1:0]      cfg_data      = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_cfg_ready;

    logic [CFG_W-1:0]  timestep_model   = DT_RESET;
    logic [CFG_W-1:0]  avg_memory_model = AVG_MEM_RESET;
    logic [TEMP_W-1:0] group_average [GROUP_COUNT];
    logic              group_seeded  [GROUP_COUNT] = '{default: 1'b0};

    t_scale_result scale_expected_q[$];
    t_scale_result want;
    int unsigned   fail_count      = 0;
    int unsigned   cycle_count     = 0;
    int unsigned   hold_cycles_req = 0;
    bit            idle_enable     = 1'b1;

    weak_coupling_temperature_scaler_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("weak_coupling_temperature_scaler_unit_test NOT OK");
        $finish;
    end

    function automatic int unsigned floor_sqrt(int unsigned v);
        int unsigned r;
        int unsigned c;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            c = r | (32'd1 << b);
            if (c * c <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [TEMP_W-1:0] annealed_target(logic [TEMP_W-1:0] ref_temp,
                                                          logic signed [FAC_W-1:0] anneal);
        longint unsigned r;
        longint unsigned f;
        longint unsigned prod;
        if (anneal <= 0) begin
            return '0;
        end
        r = ref_temp;
        f = anneal;
        prod = (r * f + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
        return (prod > TEMP_MAX) ? TEMP_MAX : prod[TEMP_W-1:0];
    endfunction

    // radicand is num/den = 1 + dt/tau*(target/avg - 1), scaled by tau*avg
    function automatic logic [SCALE_W-1:0] radicand_scale(logic [CFG_W-1:0] dt,
                                                          logic [TAU_W-1:0] tau,
                                                          logic [TEMP_W-1:0] target,
                                                          logic [TEMP_W-1:0] avg);
        longint      d, t, a, tau_l, den, num;
        logic [127:0] quot;
        int unsigned root;
        d = dt;
        t = target;
        a = avg;
        tau_l = tau;
        den = tau_l * a;
        num = den + d * (t - a);
        if (num <= 0) begin
            return SCALE_MIN;
        end
        if (num * 25 <= den * 16) begin
            return SCALE_MIN;
        end
        if (num * 16 >= den * 25) begin
            return SCALE_MAX;
        end
        quot = ({64'd0, num} << (2 * FRAC_SHIFT)) / {64'd0, den};
        root = floor_sqrt(quot[31:0]);
        if (root < SCALE_MIN) begin
            return SCALE_MIN;
        end
        if (root > SCALE_MAX) begin
            return SCALE_MAX;
        end
        return SCALE_W'(root);
    endfunction

    function automatic t_scale_result predict_result(t_coupling_item it);
        t_scale_result     res;
        logic [TEMP_W-1:0] target;
        longint unsigned   n;
        longint unsigned   acc;
        res.group = it.group;
        target = annealed_target(it.ref_temp, it.anneal);
        if (!group_seeded[it.group]) begin
            group_average[it.group] = target;
            group_seeded[it.group] = 1'b1;
        end
        n = (avg_memory_model == 0) ? 64'd1 : 64'(avg_memory_model);
        acc = (n - 1) * group_average[it.group] + it.measured + n / 2;
        acc = acc / n;
        res.average = (acc > TEMP_MAX) ? TEMP_MAX : acc[TEMP_W-1:0];
        group_average[it.group] = res.average;
        if (it.coupling_on && res.average != 0 && it.tau != 0) begin
            res.scale = radicand_scale(timestep_model, it.tau, target, res.average);
        end else begin
            res.scale = SCALE_ONE;
        end
        return res;
    endfunction

    function automatic t_coupling_item make_item(int unsigned g, int unsigned meas,
                                                 int unsigned ref_t, int unsigned tau,
                                                 int fac, bit on);
        t_coupling_item it;
        it.group       = GROUP_W'(g);
        it.measured    = TEMP_W'(meas);
        it.ref_temp    = TEMP_W'(ref_t);
        it.tau         = TAU_W'(tau);
        it.anneal      = FAC_W'(fac);
        it.coupling_on = on;
        return it;
    endfunction

    function automatic t_coupling_item random_item();
        t_coupling_item it;
        int unsigned    base;
        int unsigned    dev;
        if ($urandom_range(99) < 25) begin
            it.group       = GROUP_W'($urandom());
            it.measured    = TEMP_W'($urandom());
            it.ref_temp    = TEMP_W'($urandom());
            it.tau         = TAU_W'($urandom());
            it.anneal      = FAC_W'($urandom());
            it.coupling_on = 1'($urandom());
            return it;
        end
        base = $urandom_range(20 * 256, 2000 * 256);
        case ($urandom_range(2))
            0: dev = base / 100;
            1: dev = base / 20;
            default: dev = base * 3 / 10;
        endcase
        it.group       = GROUP_W'($urandom_range(GROUP_COUNT - 1));
        it.ref_temp    = TEMP_W'(base);
        it.measured    = TEMP_W'(base - dev + $urandom_range(2 * dev));
        it.tau         = ($urandom_range(3) == 0) ? TAU_W'($urandom_range(1, 200))
                                                  : TAU_W'($urandom_range(200, 200000));
        it.anneal      = FAC_W'($urandom_range(12000, 20000));
        it.coupling_on = ($urandom_range(19) != 0);
        return it;
    endfunction

    task automatic send_item(input t_coupling_item it);
        int unsigned gap;
        if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            gap = $urandom_range(1, 80);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.anneal, it.tau, it.ref_temp, it.measured, it.group};
        s_axis_tuser  <= it.coupling_on;
        do @(posedge i_clk); while (!o_s_axis_tready);
        scale_expected_q.push_back(predict_result(it));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (scale_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_coupling_regs(input logic [CFG_W-1:0] dt, input logic [CFG_W-1:0] mem);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TIMESTEP;
        cfg_data  <= dt;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_index <= REG_AVG_MEMORY;
        cfg_data  <= mem;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        timestep_model   = dt;
        avg_memory_model = mem;
    endtask

    task automatic test_reset_defaults();
        send_item(make_item(0, TEMP_300K, TEMP_300K, 1000, ANNEAL_ONE, 1'b0));
        send_item(make_item(1, 0, TEMP_300K, 1000, ANNEAL_ONE, 1'b1));
        send_item(make_item(2, TEMP_300K, TEMP_300K, 0, ANNEAL_ONE, 1'b1));
        send_item(make_item(3, 25600, TEMP_300K, 1, -ANNEAL_ONE, 1'b1));
        send_item(make_item(3, 100, 0, 3, ANNEAL_ONE, 1'b1));
        // radicand exactly at the lower and the upper bound
        send_item(make_item(1, 100, 10, 5, ANNEAL_ONE, 1'b1));
        send_item(make_item(2, 100, 550, 16, ANNEAL_ONE, 1'b1));
        send_item(make_item(4, 100, 2560000, 1, ANNEAL_ONE, 1'b1));
        send_item(make_item(5, TEMP_300K, 80000, 100, ANNEAL_ONE, 1'b1));
        send_item(make_item(6, TEMP_300K, TEMP_300K, 10, 0, 1'b1));
        send_item(make_item(7, TEMP_300K, TEMP_300K, 10, -32768, 1'b1));
        send_item(make_item(7, TEMP_MAX, TEMP_MAX, TAU_MAX, 32767, 1'b1));
        send_item(make_item(0, TEMP_MAX, 0, TAU_MAX, ANNEAL_ONE, 1'b1));
        send_item(make_item(5, 1, TEMP_MAX, 1, 32767, 1'b1));
        drain_results();
    endtask

    task automatic test_seeding();
        load_coupling_regs(10'd10, 10'd8);
        for (int g = 8; g < GROUP_COUNT; g++) begin
            send_item(make_item(g, (g == 15) ? 0 : TEMP_300K + g * 1000, TEMP_300K, 500,
                                (g == 15) ? 32767 : ANNEAL_ONE + (g - 8) * 500, 1'b1));
        end
        send_item(make_item(8, TEMP_300K, TEMP_300K, 500, ANNEAL_ONE, 1'b1));
        drain_results();
    endtask

    task automatic test_register_sweep();
        for (int s = 0; s < 6; s++) begin
            load_coupling_regs(SWEEP_DT[s], SWEEP_MEM[s]);
            repeat (SWEEP_ITEMS) send_item(random_item());
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        hold_cycles_req = HOLD_CYCLES;
        repeat (60) send_item(random_item());
        drain_results();
    endtask

    task automatic test_steady_flow();
        idle_enable = 1'b0;
        load_coupling_regs(10'd2, 10'd4);
        repeat (60) send_item(random_item());
        drain_results();
        idle_enable = 1'b1;
    endtask

    initial begin : result_sink
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_cycles_req != 0) begin
                n = hold_cycles_req;
                hold_cycles_req = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_axis_tready) begin
            if (scale_expected_q.size() == 0) begin
                $error("result transfer with none pending: tdata %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = scale_expected_q.pop_front();
                if (o_m_axis_tdata[OFF_SCALE-1:0] !== want.group) begin
                    $error("group_out: expected %0d, got %0d", want.group,
                           o_m_axis_tdata[OFF_SCALE-1:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[OFF_AVG-1:OFF_SCALE] !== want.scale) begin
                    $error("scale: expected %0d, got %0d", want.scale,
                           o_m_axis_tdata[OFF_AVG-1:OFF_SCALE]);
                    fail_count++;
                end
                if (o_m_axis_tdata[OUT_BITS-1:OFF_AVG] !== want.average) begin
                    $error("average_temp: expected %0d, got %0d", want.average,
                           o_m_axis_tdata[OUT_BITS-1:OFF_AVG]);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_seeding();
        test_register_sweep();
        test_output_backpressure();
        test_steady_flow();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("weak_coupling_temperature_scaler_unit_test OK");
        end else begin
            $display("weak_coupling_temperature_scaler_unit_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wcts_pkg.sv
hw/rtl/wcts_ram.sv
hw/rtl/weak_coupling_temperature_scaler_unit.sv
test/weak_coupling_temperature_scaler_unit_test.sv
